FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes, character codes and the result type of the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int CURSOR_W = 11;
    localparam int WORD_W   = 16;
    localparam int ATTR_W   = 8;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;
    localparam int TAB_STOP        = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_location;
        logic [WORD_W-1:0]   cell_word;
        logic                scrolled;
    } tcw_result_t;

endpackage

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: request, response and
// attribute write.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   char_code;
    logic [CURSOR_W-1:0] cell_index;

    modport source (output valid, output cmd, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_location;
    logic [WORD_W-1:0]   cell_word;
    logic                scrolled;

    modport source (output valid, output cursor_location, output cell_word,
                    output scrolled, input ready);
    modport sink (input valid, input cursor_location, input cell_word,
                  input scrolled, output ready);
endinterface

interface tcw_cfg_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] attribute;

    modport source (output valid, output attribute, input ready);
    modport sink (input valid, input attribute, output ready);
endinterface

FILE: rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tcw_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [tcw_pkg::WORD_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Cursor state and command sequencer: interprets put bytes, walks the screen
// memory for reset fill, clear and scroll, and forms the result.
// ----------------------------------------------------------------------------
module tcw_engine #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int AW      = $clog2(CELLS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tcw_in_if.sink                     req,
    input  logic [tcw_pkg::ATTR_W-1:0] attribute,
    output tcw_pkg::tcw_result_t       res,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [tcw_pkg::WORD_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_raddr,
    input  logic [tcw_pkg::WORD_W-1:0] mem_rdata
);
    import tcw_pkg::*;

    localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;
    localparam int CW  = $clog2(COLUMNS + TAB_STOP);
    localparam int RW  = $clog2(ROWS + 1);
    localparam int LXW = (AW > CURSOR_W) ? AW : CURSOR_W;
    localparam int IXW = (AW + 1 > CURSOR_W) ? AW + 1 : CURSOR_W;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_CLEAR,
        ST_LOC
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [LXW-1:0]    loc_reg, loc_next;
    logic [AW-1:0]     walk_reg, walk_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              pend_blank_reg, pend_blank_next;
    logic              scrolled_reg, scrolled_next;
    logic              hit_reg, hit_next;

    logic              accept;
    logic              walk_last;
    logic              walk_in_shift;
    logic [AW:0]       walk_src;
    logic [IXW-1:0]    idx_ext;
    logic              idx_hit;
    logic              printable;
    logic [WORD_W-1:0] blank;
    logic [LXW-1:0]    loc_calc;
    logic [CW-1:0]     col_t;
    logic [RW-1:0]     row_t;

    assign accept        = req.valid && req.ready;
    assign req.ready     = (state_reg == ST_IDLE);
    assign walk_last     = (walk_reg == AW'(CELLS - 1));
    assign walk_in_shift = ({1'b0, walk_reg} < (AW + 1)'(SHIFT_CELLS));
    assign walk_src      = {1'b0, walk_reg} + (AW + 1)'(COLUMNS);
    assign idx_ext       = IXW'(req.cell_index);
    assign idx_hit       = (idx_ext < IXW'(CELLS));
    assign printable     = (req.char_code inside {[CH_SPACE:CH_TILDE]});
    assign blank         = {attribute, CH_SPACE};
    assign loc_calc      = LXW'(row_reg) * LXW'(COLUMNS) + LXW'(col_reg);

    assign res_valid           = (state_reg == ST_LOC);
    assign res.cursor_location = loc_calc[CURSOR_W-1:0];
    assign res.cell_word       = hit_reg ? mem_rdata : '0;
    assign res.scrolled        = scrolled_reg;

    // cursor update for a put byte
    always_comb
    begin
        col_t = col_reg;
        row_t = row_reg;
        case (req.char_code)
            CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_t = col_reg - CW'(1);
                end
            end
            CH_TAB:    col_t = (col_reg + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
            CH_CR:     col_t = '0;
            CH_LF:
            begin
                col_t = '0;
                row_t = row_reg + RW'(1);
            end
            default:
            begin
                if (printable)
                begin
                    col_t = col_reg + CW'(1);
                end
            end
        endcase
        if (col_t >= CW'(COLUMNS))
        begin
            col_t = '0;
            row_t = row_t + RW'(1);
        end
    end

    // memory ports: pending scroll write first, then fill walks, then put
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = loc_reg[AW-1:0];
        mem_wdata = {attribute, req.char_code};
        mem_re    = 1'b0;
        mem_raddr = walk_src[AW-1:0];
        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_blank_reg ? blank : mem_rdata;
        end
        else if (state_reg == ST_INIT || state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = walk_reg;
            mem_wdata = (state_reg == ST_INIT) ? '0 : blank;
        end
        else if (accept && req.cmd == CMD_PUT && printable)
        begin
            mem_we = 1'b1;
        end

        if (state_reg == ST_SCROLL)
        begin
            mem_re = walk_in_shift;
        end
        else if (accept && req.cmd == CMD_READ)
        begin
            mem_re    = idx_hit;
            mem_raddr = idx_ext[AW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        loc_next        = loc_reg;
        walk_next       = walk_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        scrolled_next   = scrolled_reg;
        hit_next        = hit_reg;
        case (state_reg)
            ST_INIT:
            begin
                walk_next = walk_reg + AW'(1);
                if (walk_last)
                begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    hit_next      = 1'b0;
                    walk_next     = '0;
                    state_next    = ST_LOC;
                    case (req.cmd)
                        CMD_PUT:
                        begin
                            col_next = col_t;
                            row_next = row_t;
                            if (row_t >= RW'(ROWS))
                            begin
                                row_next      = RW'(ROWS - 1);
                                scrolled_next = 1'b1;
                                state_next    = ST_SCROLL;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:  hit_next = idx_hit;
                        default:   hit_next = 1'b0;
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // read one row below, write back in the next cycle
                pend_valid_next = 1'b1;
                pend_addr_next  = walk_reg;
                pend_blank_next = !walk_in_shift;
                walk_next       = walk_reg + AW'(1);
                if (walk_last)
                begin
                    state_next = ST_LOC;
                end
            end
            ST_CLEAR:
            begin
                walk_next = walk_reg + AW'(1);
                if (walk_last)
                begin
                    state_next = ST_LOC;
                end
            end
            ST_LOC:
            begin
                if (res_ready)
                begin
                    loc_next   = loc_calc;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            loc_reg        <= '0;
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            scrolled_reg   <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            loc_reg        <= loc_next;
            walk_reg       <= walk_next;
            pend_valid_reg <= pend_valid_next;
            scrolled_reg   <= scrolled_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
    end

endmodule

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine with a ROWS x COLUMNS screen memory and a cursor.
// ----------------------------------------------------------------------------
// A put, read or unused command is taken in its accept cycle, which updates
// the cursor and issues the cell write or read; the engine then forms the
// linear cursor location in ST_LOC and moves it into the response register
// once that register is free. A clear, and a put that scrolls, walk every
// cell once through the single write port of the screen memory (scrolling
// reads the cell one row below and writes it back in the next cycle).
// After reset the block zeroes every cell of the memory in one pass with
// req.ready low. Attribute writes are always taken; write the attribute
// only while no request is in flight, since a clear or scroll walk in progress
// fills its blanks with whatever attribute is current. The response register
// lets the next request enter while a result waits.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic    clk,
    input  logic    rst_n,
    tcw_in_if.sink  req,
    tcw_out_if.source rsp,
    tcw_cfg_if.sink cfg
);
    import tcw_pkg::*;

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int AW          = $clog2(CELLS);
    localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;

    logic [ATTR_W-1:0] attribute_reg;
    logic              out_valid_reg;
    tcw_result_t       out_data_reg;

    tcw_result_t       res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .attribute (attribute_reg),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg.ready = 1'b1;
    assign res_ready = !out_valid_reg || rsp.ready;

    assign rsp.valid           = out_valid_reg;
    assign rsp.cursor_location = out_data_reg.cursor_location;
    assign rsp.cell_word       = out_data_reg.cell_word;
    assign rsp.scrolled        = out_data_reg.scrolled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                attribute_reg <= cfg.attribute;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

`ifndef SYNTH
    // the engine is not ready in the cycle after it accepts a request
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted on two consecutive cycles");

    // a finished result waits in the engine until the response register frees
    a_res_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped or changed while waiting");

    a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (CELLS > 2048) || (rsp.cursor_location < CELLS))
        else $error("cursor location beyond screen");

    // after a scroll the cursor sits on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.scrolled |->
            (CELLS > 2048) || (rsp.cursor_location >= SHIFT_CELLS))
        else $error("scroll left cursor above bottom row");
`endif

endmodule

FILE: dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A directed table covers
// field extremes, every control byte, row wrap, scrolling, clear and reads out
// of range. Random phases of text, line-heavy and noisy traffic follow, each
// under its own attribute. A shadow screen and cursor predict each response
// that the table does not give. Both channel ends idle at random, and the
// bench adds one long response hold-off and one full drain inside a phase.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS      = DEFAULT_COLUMNS;
    localparam int ROWS         = DEFAULT_ROWS;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int INDEX_MAX    = (1 << CURSOR_W) - 1;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 120;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REQUESTS = 1800;
    localparam int CYCLE_LIMIT  = 3 * (MAX_REQUESTS * (CELLS + 2 + 6) + CELLS + LONG_HOLD);
    localparam int N_SCRIPT     = 30;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // traffic mixes of the random phases
    localparam int MIX_TEXT  = 0;
    localparam int MIX_LINES = 1;
    localparam int MIX_NOISE = 2;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [CHAR_W-1:0]   ch;
        logic [CURSOR_W-1:0] idx;
        int                  reps;
        bit                  typed;
        logic [CURSOR_W-1:0] cur;
        logic [WORD_W-1:0]   word;
        logic                scr;
    } script_row_t;

    logic clk;
    logic rst_n;

    tcw_in_if  req_if ();
    tcw_out_if rsp_if ();
    tcw_cfg_if cfg_if ();

    text_console_writer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // shadow of the console state
    logic [WORD_W-1:0] screen_mem [CELLS];
    logic [6:0]        cur_col;
    logic [4:0]        cur_row;
    logic [ATTR_W-1:0] attr_now;

    tcw_result_t expected_results [$];
    script_row_t script_rows [N_SCRIPT];

    int  mismatches;
    int  sent_count;
    int  n_reads;
    int  n_clears;
    int  n_scrolls;
    int  n_attrs;
    bit  long_hold_due;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic tcw_result_t console_predict(input logic [CMD_W-1:0] cmd,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [CURSOR_W-1:0] idx);
        tcw_result_t       res;
        logic [WORD_W-1:0] blank;
        res   = '0;
        blank = {attr_now, CH_SPACE};
        case (cmd)
            CMD_PUT:
            begin
                if (ch == CH_BACKSPACE)
                begin
                    if (cur_col != 0)
                        cur_col = cur_col - 7'd1;
                end
                else if (ch == CH_TAB)
                    cur_col = (cur_col + 7'(TAB_STOP)) & ~7'(TAB_STOP - 1);
                else if (ch == CH_CR)
                    cur_col = '0;
                else if (ch == CH_LF)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                end
                else if (ch >= CH_SPACE && ch <= CH_TILDE)
                begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {attr_now, ch};
                    cur_col = cur_col + 7'd1;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                end
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_mem[i] = blank;
                    cur_row      = 5'(ROWS - 1);
                    res.scrolled = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_mem[i] = blank;
                cur_col = '0;
                cur_row = '0;
            end
            CMD_READ:
            begin
                if (idx < CELLS)
                    res.cell_word = screen_mem[idx];
            end
            default:
            begin
            end
        endcase
        res.cursor_location = CURSOR_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                input logic [CURSOR_W-1:0] idx, input bit typed,
                                input tcw_result_t typed_res);
        tcw_result_t predicted;
        int          idle;
        @(negedge clk);
        req_if.valid      = 1'b1;
        req_if.cmd        = cmd;
        req_if.char_code  = ch;
        req_if.cell_index = idx;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = console_predict(cmd, ch, idx);
        expected_results.push_back(typed ? typed_res : predicted);
        if (cmd == CMD_READ)
            n_reads++;
        if (cmd == CMD_CLEAR)
            n_clears++;
        if (predicted.scrolled)
            n_scrolls++;
        sent_count++;
        idle = ((sent_count % 160) < 40) ? 0 : $urandom_range(0, 3);
        if (idle > 0)
        begin
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_results;
        @(negedge clk);
        req_if.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_if.valid     = 1'b1;
        cfg_if.attribute = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        attr_now = value;
        n_attrs++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic pick_request(input int mix, output logic [CMD_W-1:0] cmd,
                                output logic [CHAR_W-1:0] ch,
                                output logic [CURSOR_W-1:0] idx, output bit ignored);
        int r;
        r   = $urandom_range(0, 99);
        cmd = CMD_PUT;
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = CURSOR_W'($urandom_range(0, INDEX_MAX));
        if (mix == MIX_NOISE)
        begin
            if (r < 3)
                cmd = CMD_CLEAR;
            else
            begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_PUT;
                    1: cmd = CMD_READ;
                    default: cmd = CMD_UNUSED;
                endcase
            end
        end
        else if (mix == MIX_LINES)
        begin
            if (r < 35)
                ch = CH_LF;
            else if (r < 45)
                ch = CH_TAB;
            else if (r < 48)
                ch = CH_BACKSPACE;
            else if (r < 50)
                ch = CH_CR;
            else if (r < 85)
                ch = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
            else
            begin
                cmd = CMD_READ;
                idx = (r < 98) ? CURSOR_W'($urandom_range(0, CELLS - 1)) :
                                 CURSOR_W'($urandom_range(CELLS, INDEX_MAX));
            end
        end
        else
        begin
            if (r < 4)
            begin
                case ($urandom_range(0, 3))
                    0: ch = CH_BACKSPACE;
                    1: ch = CH_TAB;
                    2: ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            else if (r < 80)
                ch = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
            else if (r < 97)
            begin
                cmd = CMD_READ;
                idx = CURSOR_W'($urandom_range(0, CELLS - 1));
            end
            else if (r < 98)
            begin
                cmd = CMD_READ;
                idx = CURSOR_W'($urandom_range(CELLS, INDEX_MAX));
            end
            else if (r < 99)
                cmd = CMD_CLEAR;
        end
        ignored = (cmd == CMD_UNUSED) ||
                  (cmd == CMD_PUT && !(ch >= CH_SPACE && ch <= CH_TILDE) &&
                   ch != CH_BACKSPACE && ch != CH_TAB && ch != CH_CR && ch != CH_LF);
    endtask

    // response side: random stalls, one long hold-off on demand
    initial
    begin : response_side
        int          stall;
        int          got;
        tcw_result_t exp_res;
        got           = 0;
        rsp_if.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                stall         = LONG_HOLD;
            end
            else if ((got % 160) >= 80 && (got % 160) < 120)
                stall = 0;
            else
                stall = $urandom_range(0, 3);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_if.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_if.ready = 1'b1;
            @(posedge clk);
            while (!rsp_if.valid)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("unexpected response: cursor_location %0d cell_word %h",
                       rsp_if.cursor_location, rsp_if.cell_word);
                mismatches++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (rsp_if.cursor_location !== exp_res.cursor_location)
                begin
                    $error("cursor_location: expected %0d, actual %0d",
                           exp_res.cursor_location, rsp_if.cursor_location);
                    mismatches++;
                end
                if (rsp_if.cell_word !== exp_res.cell_word)
                begin
                    $error("cell_word: expected %h, actual %h",
                           exp_res.cell_word, rsp_if.cell_word);
                    mismatches++;
                end
                if (rsp_if.scrolled !== exp_res.scrolled)
                begin
                    $error("scrolled: expected %0b, actual %0b",
                           exp_res.scrolled, rsp_if.scrolled);
                    mismatches++;
                end
            end
            got++;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycles, expected_results.size());
        $display("text_console_writer: mismatch");
        $finish;
    end

    initial
    begin : request_side
        logic [CMD_W-1:0]    cmd;
        logic [CHAR_W-1:0]   ch;
        logic [CURSOR_W-1:0] idx;
        bit                  ignored;
        int                  useful;
        int                  k;
        int                  mix;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_PUT;
        req_if.char_code  = '0;
        req_if.cell_index = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.attribute  = ATTR_RESET;
        mismatches        = 0;
        sent_count        = 0;
        n_reads           = 0;
        n_clears          = 0;
        n_scrolls         = 0;
        n_attrs           = 0;
        long_hold_due     = 1'b0;
        attr_now          = ATTR_RESET;
        cur_col           = '0;
        cur_row           = '0;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = '0;

        // cmd, char, index, repeat, typed, cursor, word, scrolled (typed on last repeat)
        script_rows = '{
            '{CMD_READ,   8'h00,        11'd0,    1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_READ,   8'h00,        11'd1999, 1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_READ,   8'h00,        11'd2047, 1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_PUT,    8'h41,        11'd0,    1, 1'b1, 11'd1,    16'h0000, 1'b0},
            '{CMD_READ,   8'h00,        11'd0,    1, 1'b1, 11'd1,    16'h0F41, 1'b0},
            '{CMD_PUT,    CH_SPACE,     11'd0,    1, 1'b1, 11'd2,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_TILDE,     11'd0,    1, 1'b1, 11'd3,    16'h0000, 1'b0},
            '{CMD_PUT,    8'h7F,        11'd0,    1, 1'b1, 11'd3,    16'h0000, 1'b0},
            '{CMD_PUT,    8'hFF,        11'd0,    1, 1'b1, 11'd3,    16'h0000, 1'b0},
            '{CMD_PUT,    8'h00,        11'd0,    1, 1'b1, 11'd3,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_BACKSPACE, 11'd0,    1, 1'b1, 11'd2,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_TAB,       11'd0,    1, 1'b1, 11'd8,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_TAB,       11'd0,    1, 1'b1, 11'd16,   16'h0000, 1'b0},
            '{CMD_PUT,    CH_CR,        11'd0,    1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_BACKSPACE, 11'd0,    1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_PUT,    CH_LF,        11'd0,    1, 1'b1, 11'd80,   16'h0000, 1'b0},
            '{CMD_UNUSED, 8'h5A,        11'd5,    1, 1'b1, 11'd80,   16'h0000, 1'b0},
            '{CMD_READ,   8'h00,        11'd2,    1, 1'b1, 11'd80,   16'h0F7E, 1'b0},
            '{CMD_PUT,    8'h71,        11'd0,   79, 1'b1, 11'd159,  16'h0000, 1'b0},
            '{CMD_PUT,    8'h72,        11'd0,    1, 1'b1, 11'd160,  16'h0000, 1'b0},
            '{CMD_PUT,    CH_TAB,       11'd0,   10, 1'b1, 11'd240,  16'h0000, 1'b0},
            '{CMD_PUT,    CH_LF,        11'd0,   21, 1'b1, 11'd1920, 16'h0000, 1'b0},
            '{CMD_PUT,    8'h65,        11'd0,   79, 1'b1, 11'd1999, 16'h0000, 1'b0},
            '{CMD_PUT,    8'h66,        11'd0,    1, 1'b1, 11'd1920, 16'h0000, 1'b1},
            '{CMD_READ,   8'h00,        11'd1919, 1, 1'b1, 11'd1920, 16'h0F66, 1'b0},
            '{CMD_READ,   8'h00,        11'd1920, 1, 1'b1, 11'd1920, 16'h0F20, 1'b0},
            '{CMD_PUT,    CH_LF,        11'd0,    1, 1'b1, 11'd1920, 16'h0000, 1'b1},
            '{CMD_READ,   8'h00,        11'd1839, 1, 1'b0, 11'd0,    16'h0000, 1'b0},
            '{CMD_CLEAR,  8'h00,        11'd0,    1, 1'b1, 11'd0,    16'h0000, 1'b0},
            '{CMD_READ,   8'h00,        11'd1999, 1, 1'b1, 11'd0,    16'h0F20, 1'b0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script_rows[i])
        begin
            for (int n = 1; n <= script_rows[i].reps; n++)
                send_request(script_rows[i].cmd, script_rows[i].ch, script_rows[i].idx,
                             script_rows[i].typed && n == script_rows[i].reps,
                             tcw_result_t'{script_rows[i].cur, script_rows[i].word,
                                           script_rows[i].scr});
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            // attribute changes only with nothing in flight
            wait_all_results();
            if (phase == 0)
                write_attribute(8'h00);
            else if (phase == 1)
                write_attribute(8'hFF);
            else
                write_attribute(ATTR_W'($urandom_range(0, 255)));
            mix    = (phase % 4 == 1) ? MIX_LINES : (phase % 4 == 2) ? MIX_NOISE : MIX_TEXT;
            useful = 0;
            k      = 0;
            while (useful < PHASE_ITEMS)
            begin
                pick_request(mix, cmd, ch, idx, ignored);
                if (phase == 2 && k == 40)
                    long_hold_due = 1'b1;
                if (phase == 5 && k == 75)
                    wait_all_results();
                send_request(cmd, ch, idx, 1'b0, '0);
                if (!ignored)
                    useful++;
                k++;
            end
        end

        wait_all_results();
        repeat (8) @(posedge clk);
        $display("covered %0d requests: %0d reads, %0d clears, %0d scrolling puts",
                 sent_count, n_reads, n_clears, n_scrolls);
        $display("attribute settings: %0d incl. 0x00 and 0xff, with a long hold-off and a drain",
                 n_attrs + 1);
        if (mismatches == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

endmodule
